### rtl/tcce_pkg.sv
// Shared types, codes and defaults for the text console cursor engine.
package tcce_pkg;

  localparam int TAB_STOP_DEF    = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Input op codes
  localparam logic [2:0] OP_CHAR       = 3'd0;
  localparam logic [2:0] OP_SET_CURSOR = 3'd1;
  localparam logic [2:0] OP_ERASE_DISP = 3'd2;
  localparam logic [2:0] OP_ERASE_LINE = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  // Erase modes
  localparam logic [1:0] ERASE_TO_END   = 2'd0;
  localparam logic [1:0] ERASE_TO_START = 2'd1;
  localparam logic [1:0] ERASE_ALL      = 2'd2;

  // Result actions
  localparam logic [2:0] ACT_NONE         = 3'd0;
  localparam logic [2:0] ACT_DRAW         = 3'd1;
  localparam logic [2:0] ACT_CLEAR_CELL   = 3'd2;
  localparam logic [2:0] ACT_SCROLL       = 3'd3;
  localparam logic [2:0] ACT_CLEAR_RANGE  = 3'd4;
  localparam logic [2:0] ACT_CLEAR_SCREEN = 3'd5;

  // Character codes
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_PRINT_LO  = 8'h20;
  localparam logic [7:0] CH_DEL       = 8'h7F;

  // Register indexes
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_ENABLE  = 2'd2;

  localparam logic [8:0] COLUMNS_RST = 9'd80;
  localparam logic [8:0] ROWS_RST    = 9'd25;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] char_code;
    logic [7:0] target_col;
    logic [7:0] target_row;
    logic [1:0] erase_mode;
  } tcce_in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] glyph;
    logic [7:0] cell_col;
    logic [7:0] cell_row;
    logic [7:0] end_col;
    logic [7:0] end_row;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
    logic       last;
  } tcce_out_t;

  // Effective grid settings seen by the front end
  typedef struct packed {
    logic [7:0] last_col;
    logic [7:0] bottom_row;
    logic       enable;
  } tcce_cfg_t;

  // Queue entry: first result plus a flag for a trailing scroll
  typedef struct packed {
    tcce_out_t res;
    logic      scroll_after;
  } tcce_cmd_t;

endpackage

### rtl/tcce_front.sv
// Front end: accepts items, updates the cursor and builds queue entries.
module tcce_front import tcce_pkg::*; #(
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  tcce_cfg_t cfg,
  input  logic      accept,
  input  tcce_in_t  item,
  output tcce_cmd_t cmd
);

  localparam int TAB_RECIP = (65536 + TAB_STOP - 1) / TAB_STOP;

  logic [7:0]  col_r, row_r;
  logic [7:0]  col_nxt, row_nxt;
  logic [7:0]  col_c, row_c;
  logic        at_bottom_row;
  logic [7:0]  nl_row;
  logic [23:0] tab_prod;
  logic [7:0]  tab_q;
  logic [12:0] tab_wide;
  tcce_out_t   res;
  logic        two;

  // Clamp a cursor left outside a shrunk grid
  assign col_c = (col_r > cfg.last_col) ? cfg.last_col : col_r;
  assign row_c = (row_r > cfg.bottom_row) ? cfg.bottom_row : row_r;

  assign at_bottom_row = (row_c == cfg.bottom_row);
  assign nl_row        = at_bottom_row ? row_c : row_c + 8'd1;

  // Next tab stop: quotient by reciprocal, exact for 8-bit columns
  assign tab_prod = 24'(col_c) * 24'(TAB_RECIP);
  assign tab_q    = tab_prod[23:16];
  assign tab_wide = 13'((13'(tab_q) + 13'd1) * 13'(TAB_STOP));

  always_comb begin
    res        = '0;
    res.action = ACT_NONE;
    two        = 1'b0;
    col_nxt    = col_c;
    row_nxt    = row_c;
    case (item.op)
      OP_SET_CURSOR: begin
        col_nxt = (item.target_col > cfg.last_col) ? cfg.last_col : item.target_col;
        row_nxt = (item.target_row > cfg.bottom_row) ? cfg.bottom_row : item.target_row;
      end
      OP_CHAR: begin
        if (cfg.enable) begin
          case (item.char_code)
            CH_LF: begin
              col_nxt = 8'd0;
              row_nxt = nl_row;
              if (at_bottom_row) res.action = ACT_SCROLL;
            end
            CH_CR: begin
              col_nxt = 8'd0;
            end
            CH_TAB: begin
              if (tab_wide > 13'(cfg.last_col)) begin
                col_nxt = 8'd0;
                row_nxt = nl_row;
                if (at_bottom_row) res.action = ACT_SCROLL;
              end else begin
                col_nxt = tab_wide[7:0];
              end
            end
            CH_BS: begin
              if (col_c != 8'd0) begin
                col_nxt      = col_c - 8'd1;
                res.action   = ACT_CLEAR_CELL;
                res.cell_col = col_c - 8'd1;
                res.cell_row = row_c;
              end
            end
            default: begin
              if (item.char_code >= CH_PRINT_LO && item.char_code < CH_DEL) begin
                res.action   = ACT_DRAW;
                res.glyph    = item.char_code[6:0];
                res.cell_col = col_c;
                res.cell_row = row_c;
                if (col_c == cfg.last_col) begin
                  col_nxt = 8'd0;
                  row_nxt = nl_row;
                  two     = at_bottom_row;
                end else begin
                  col_nxt = col_c + 8'd1;
                end
              end
            end
          endcase
        end
      end
      OP_ERASE_DISP: begin
        if (cfg.enable) begin
          case (item.erase_mode)
            ERASE_ALL: begin
              res.action = ACT_CLEAR_SCREEN;
              col_nxt    = 8'd0;
              row_nxt    = 8'd0;
            end
            ERASE_TO_END: begin
              res.action   = ACT_CLEAR_RANGE;
              res.cell_col = col_c;
              res.cell_row = row_c;
              res.end_col  = cfg.last_col;
              res.end_row  = cfg.bottom_row;
            end
            ERASE_TO_START: begin
              res.action  = ACT_CLEAR_RANGE;
              res.end_col = col_c;
              res.end_row = row_c;
            end
            default: ;
          endcase
        end
      end
      OP_ERASE_LINE: begin
        if (cfg.enable) begin
          case (item.erase_mode)
            ERASE_ALL: begin
              res.action   = ACT_CLEAR_RANGE;
              res.cell_row = row_c;
              res.end_col  = cfg.last_col;
              res.end_row  = row_c;
            end
            ERASE_TO_END: begin
              res.action   = ACT_CLEAR_RANGE;
              res.cell_col = col_c;
              res.cell_row = row_c;
              res.end_col  = cfg.last_col;
              res.end_row  = row_c;
            end
            ERASE_TO_START: begin
              res.action   = ACT_CLEAR_RANGE;
              res.cell_row = row_c;
              res.end_col  = col_c;
              res.end_row  = row_c;
            end
            default: ;
          endcase
        end
      end
      OP_CLEAR: begin
        if (cfg.enable) begin
          res.action = ACT_CLEAR_SCREEN;
          col_nxt    = 8'd0;
          row_nxt    = 8'd0;
        end
      end
      default: ;
    endcase
    res.cursor_col = col_nxt;
    res.cursor_row = row_nxt;
    res.last       = 1'b1;
  end

  assign cmd.res          = res;
  assign cmd.scroll_after = two;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 8'd0;
      row_r <= 8'd0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### rtl/tcce_queue.sv
// Short FIFO of commands between the front and back ends.
module tcce_queue import tcce_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tcce_cmd_t push_data,
  output logic      full,
  input  logic      pop,
  output tcce_cmd_t head,
  output logic      empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tcce_cmd_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: ;
      endcase
    end
  end

endmodule

### rtl/tcce_back.sv
// Back end: expands queued commands into results and holds the output register.
module tcce_back import tcce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tcce_cmd_t head,
  input  logic      empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output tcce_out_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  tcce_out_t out_data_r, out_data_nxt;
  logic      half_r, half_nxt;
  logic      can_load;

  assign can_load = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    half_nxt      = half_r;
    pop           = 1'b0;
    if (can_load) begin
      out_valid_nxt = !empty;
      if (!empty) begin
        if (head.scroll_after && !half_r) begin
          // draw first, keep the entry for the trailing scroll
          out_data_nxt      = head.res;
          out_data_nxt.last = 1'b0;
          half_nxt          = 1'b1;
        end else if (head.scroll_after) begin
          out_data_nxt            = '0;
          out_data_nxt.action     = ACT_SCROLL;
          out_data_nxt.cursor_col = head.res.cursor_col;
          out_data_nxt.cursor_row = head.res.cursor_row;
          out_data_nxt.last       = 1'b1;
          half_nxt                = 1'b0;
          pop                     = 1'b1;
        end else begin
          out_data_nxt = head.res;
          pop          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      half_r      <= half_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/text_console_cursor_engine.sv
// Text console cursor engine: takes one item per cycle when the internal queue has room and
// the output drains; each item is queued and gives one result through the output register,
// except a printable character that wraps on the last row, which gives a draw result and
// then a scroll result. in_stall rises only when the QUEUE_DEPTH-entry command queue between
// the cursor front end and the result back end is full. Grid sizes of 0 act as 1 and above
// 256 act as 256; the cursor is clamped to the grid at the start of every item. Registers:
// 0x0 columns, 0x4 rows, 0x8 enable.
module text_console_cursor_engine import tcce_pkg::*; #(
  parameter int TAB_STOP    = TAB_STOP_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  tcce_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output tcce_out_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [8:0] columns_r, rows_r;
  logic       enable_r;
  logic       wr_en;
  tcce_cfg_t  cfg;
  tcce_cmd_t  push_cmd, head;
  logic       q_full, q_empty, q_pop, accept;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RST;
      rows_r    <= ROWS_RST;
      enable_r  <= 1'b0;
    end else if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_COLUMNS: columns_r <= cfg_pwdata[8:0];
        REG_ROWS:    rows_r    <= cfg_pwdata[8:0];
        REG_ENABLE:  enable_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_COLUMNS: cfg_prdata = {23'd0, columns_r};
      REG_ROWS:    cfg_prdata = {23'd0, rows_r};
      REG_ENABLE:  cfg_prdata = {31'd0, enable_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // Last valid column and row, with zero acting as one and sizes above 256 as 256
  always_comb begin
    if (columns_r == 9'd0)  cfg.last_col   = 8'd0;
    else if (columns_r[8])  cfg.last_col   = 8'hFF;
    else                    cfg.last_col   = 8'(columns_r - 9'd1);
    if (rows_r == 9'd0)     cfg.bottom_row = 8'd0;
    else if (rows_r[8])     cfg.bottom_row = 8'hFF;
    else                    cfg.bottom_row = 8'(rows_r - 9'd1);
    cfg.enable = enable_r;
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  tcce_front #(.TAB_STOP(TAB_STOP)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .accept (accept),
    .item   (in_data),
    .cmd    (push_cmd)
  );

  tcce_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty)
  );

  tcce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/tcce_checker.sv
// Port-level checks for the text console cursor engine, bound to the top level.
module tcce_checker import tcce_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input tcce_out_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Only a draw result can be followed by another result of the same item
  a_nonlast_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.action == ACT_DRAW)
    else $error("non-final result is not a draw");

  // The trailing scroll comes right after the draw is taken
  a_scroll_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=>
      out_valid && out_data.last && out_data.action == ACT_SCROLL)
    else $error("scroll did not follow a wrapping draw");

  // Clear screen homes the cursor
  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == ACT_CLEAR_SCREEN |->
      out_data.cursor_col == 8'd0 && out_data.cursor_row == 8'd0)
    else $error("clear screen left cursor away from home");

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
